### hdl/hsd_pkg.sv
// ============================================================================
// hsd_pkg
// Shared types and constants of the Hangul syllable decomposer: the job
// record passed from the front to the back, and the Unicode constants.
// ============================================================================
package hsd_pkg;

    // Precomposed syllable block and jamo bases
    localparam logic [15:0] SYL_BASE    = 16'hAC00;
    localparam logic [15:0] SYL_LAST    = 16'hD7A3;
    localparam logic [15:0] LEAD_BASE   = 16'h1100;
    localparam logic [15:0] VOWEL_BASE  = 16'h1161;
    localparam logic [15:0] TRAIL_BASE  = 16'h11A7;
    localparam logic [4:0]  VOWEL_COUNT = 5'd21;
    localparam logic [4:0]  TRAIL_COUNT = 5'd28;

    // UTF-8 marks
    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [7:0] JAMO_HEAD = 8'hE0;
    localparam logic [7:0] CONT_HEAD = 8'h80;

    // Reciprocals for the constant divisions of the syllable index (< 11172):
    // index / 588 = (index * 14267) >> 23, index / 28 = (index * 18725) >> 19
    localparam logic [13:0] LEAD_RECIP  = 14'd14267;
    localparam int          LEAD_SHIFT  = 23;
    localparam logic [14:0] TRAIL_RECIP = 15'd18725;
    localparam int          TRAIL_SHIFT = 19;

    // Longest result of one character: three jamo of three bytes
    localparam int MAX_OUT = 9;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One finished character or one error, ready for expansion
    typedef struct packed {
        logic            err;    // error result
        logic            syl;    // Hangul syllable to split
        logic [2:0]      len;    // byte count of the character
        logic [3:0][7:0] bytes;  // original bytes, first in [0]
        logic [13:0]     sidx;   // syllable index (code point - SYL_BASE)
        logic [4:0]      lead;   // sidx / 588
        logic [8:0]      q28;    // sidx / 28
    } job_t;

endpackage

### hdl/hsd_front.sv
// ============================================================================
// hsd_front
// Byte intake: assembles UTF-8 characters from lead and continuation bytes,
// flags errors, classifies syllables and registers one job per character.
// ============================================================================
module hsd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_eot,
    input  logic          enable,
    output logic          job_valid,
    input  logic          job_ready,
    output hsd_pkg::job_t job
);
    import hsd_pkg::*;

    logic [7:0]  pend_reg [3];
    logic [7:0]  pend_next [3];
    logic [2:0]  expected_reg, expected_next;
    logic [1:0]  held_reg, held_next;
    logic        discard_reg, discard_next;
    logic        s1_valid_reg;
    job_t        s1_job_reg;

    logic        accept;
    logic [2:0]  lead_len;
    logic [2:0]  char_len;
    logic [7:0]  chr [4];
    logic [20:0] cp;
    logic [15:0] sdiff;
    logic        emit;
    logic        emit_err;
    job_t        job_new;
    logic [27:0] lead_prod;
    logic [28:0] q28_prod;

    assign accept   = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || job_ready;

    // Classify lead byte by its length; zero marks a bad lead byte
    always_comb
    begin
        if (!in_byte[7])
            lead_len = 3'd1;
        else if (in_byte[7:5] == 3'b110)
            lead_len = 3'd2;
        else if (in_byte[7:4] == 4'b1110)
            lead_len = 3'd3;
        else if (in_byte[7:3] == 5'b11110)
            lead_len = 3'd4;
        else
            lead_len = 3'd0;
    end

    // Gather the character as it would complete on this byte
    always_comb
    begin
        char_len = (held_reg == 2'd0) ? 3'd1 : 3'({1'b0, held_reg} + 3'd1);
        for (int i = 0; i < 3; i++)
        begin
            if (3'(i) == char_len - 3'd1)
                chr[i] = in_byte;
            else
                chr[i] = pend_reg[i];
        end
        chr[3] = (char_len == 3'd4) ? in_byte : 8'h00;
        case (char_len)
            3'd1:    cp = {13'd0, chr[0]};
            3'd2:    cp = {10'd0, chr[0][4:0], chr[1][5:0]};
            3'd3:    cp = {5'd0, chr[0][3:0], chr[1][5:0], chr[2][5:0]};
            default: cp = {chr[0][2:0], chr[1][5:0], chr[2][5:0], chr[3][5:0]};
        endcase
        sdiff = cp[15:0] - SYL_BASE;
    end

    // Advance the assembly state on each accepted beat
    always_comb
    begin
        pend_next     = pend_reg;
        expected_next = expected_reg;
        held_next     = held_reg;
        discard_next  = discard_reg;
        emit          = 1'b0;
        emit_err      = 1'b0;
        if (accept)
        begin
            if (discard_reg)
            begin
                if (in_eot)
                begin
                    discard_next  = 1'b0;
                    expected_next = 3'd0;
                    held_next     = 2'd0;
                end
            end
            else if (held_reg == 2'd0)
            begin
                if (lead_len == 3'd0)
                begin
                    emit         = 1'b1;
                    emit_err     = 1'b1;
                    discard_next = !in_eot;
                end
                else if (lead_len == 3'd1)
                begin
                    emit = 1'b1;
                end
                else if (in_eot)
                begin
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
                else
                begin
                    pend_next[0]  = in_byte;
                    expected_next = lead_len;
                    held_next     = 2'd1;
                end
            end
            else if (char_len >= expected_reg)
            begin
                emit          = 1'b1;
                expected_next = 3'd0;
                held_next     = 2'd0;
            end
            else if (in_eot)
            begin
                emit          = 1'b1;
                emit_err      = 1'b1;
                expected_next = 3'd0;
                held_next     = 2'd0;
            end
            else
            begin
                pend_next[held_reg] = in_byte;
                held_next           = held_reg + 2'd1;
            end
        end
    end

    // Build the job record for a finished character or an error
    always_comb
    begin
        job_new       = '0;
        job_new.err   = emit_err;
        job_new.len   = char_len;
        job_new.syl   = !emit_err && enable &&
                        (cp >= 21'(SYL_BASE)) && (cp <= 21'(SYL_LAST));
        job_new.sidx  = sdiff[13:0];
        for (int i = 0; i < 4; i++)
        begin
            job_new.bytes[i] = chr[i];
        end
    end

    // Hold state and the registered job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 3'd0;
            held_reg     <= 2'd0;
            discard_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            expected_reg <= expected_next;
            held_reg     <= held_next;
            discard_reg  <= discard_next;
            if (accept && emit)
                s1_valid_reg <= 1'b1;
            else if (job_ready)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept && emit)
            s1_job_reg <= job_new;
    end

    // Divide the syllable index by 588 and by 28 through reciprocals
    assign lead_prod = 28'(s1_job_reg.sidx) * 28'(LEAD_RECIP);
    assign q28_prod  = 29'(s1_job_reg.sidx) * 29'(TRAIL_RECIP);

    always_comb
    begin
        job      = s1_job_reg;
        job.lead = 5'(lead_prod >> LEAD_SHIFT);
        job.q28  = 9'(q28_prod >> TRAIL_SHIFT);
    end

    assign job_valid = s1_valid_reg;

endmodule

### hdl/hsd_queue.sv
// ============================================================================
// hsd_queue
// Short job queue that decouples character intake from byte output.
// ============================================================================
module hsd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  hsd_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output hsd_pkg::job_t out_job
);
    import hsd_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_job   = entry_reg[rd_ptr_reg];

    // Move pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_job;
    end

endmodule

### hdl/hsd_back.sv
// ============================================================================
// hsd_back
// Byte output: expands one job into its result bytes (original bytes, jamo
// triples or one error beat) and drives them through an output register.
// ============================================================================
module hsd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  hsd_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          out_last,
    output logic          out_err
);
    import hsd_pkg::*;

    logic [MAX_OUT-1:0][7:0] obuf_reg, obuf_next, obuf_load;
    logic [3:0]              rem_reg, rem_next, rem_load;
    logic                    err_reg, err_next;
    logic                    ovalid_reg;
    logic [7:0]              obyte_reg;
    logic                    olast_reg;
    logic                    oerr_reg;

    logic        out_adv;
    logic        active;
    logic        pop;
    logic [8:0]  lead_x21;
    logic [13:0] q28_x28;
    logic [4:0]  vowel;
    logic [4:0]  trail;
    logic [2:0][7:0] jl, jv, jt;

    function automatic logic [2:0][7:0] jamo_bytes(input logic [15:0] cp);
        logic [2:0][7:0] b;
        b[0] = JAMO_HEAD | {4'd0, cp[15:12]};
        b[1] = CONT_HEAD | ({2'd0, cp[11:6]} & CONT_MASK);
        b[2] = CONT_HEAD | ({2'd0, cp[5:0]} & CONT_MASK);
        return b;
    endfunction

    assign out_adv   = !ovalid_reg || out_ready;
    assign active    = (rem_reg != 4'd0);
    assign pop       = job_valid && (!active || (out_adv && rem_reg == 4'd1));
    assign job_ready = pop;

    // Split the syllable and lay out the bytes of the incoming job
    always_comb
    begin
        lead_x21 = 9'(job.lead) * 9'(VOWEL_COUNT);
        q28_x28  = 14'(job.q28) * 14'(TRAIL_COUNT);
        vowel    = 5'(job.q28 - lead_x21);
        trail    = 5'(job.sidx - q28_x28);
        jl       = jamo_bytes(LEAD_BASE + 16'(job.lead));
        jv       = jamo_bytes(VOWEL_BASE + 16'(vowel));
        jt       = jamo_bytes(TRAIL_BASE + 16'(trail));
        obuf_load = '0;
        if (job.err)
        begin
            rem_load = 4'd1;
        end
        else if (job.syl)
        begin
            for (int i = 0; i < 3; i++)
            begin
                obuf_load[i]     = jl[i];
                obuf_load[i + 3] = jv[i];
                obuf_load[i + 6] = jt[i];
            end
            rem_load = (trail != 5'd0) ? 4'd9 : 4'd6;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                obuf_load[i] = job.bytes[i];
            end
            rem_load = 4'(job.len);
        end
    end

    // Shift out one byte per beat; load the next job as the last one leaves
    always_comb
    begin
        obuf_next = obuf_reg;
        rem_next  = rem_reg;
        err_next  = err_reg;
        if (active && out_adv)
        begin
            for (int i = 0; i < MAX_OUT - 1; i++)
            begin
                obuf_next[i] = obuf_reg[i + 1];
            end
            obuf_next[MAX_OUT-1] = 8'h00;
            rem_next = rem_reg - 4'd1;
        end
        if (pop)
        begin
            obuf_next = obuf_load;
            rem_next  = rem_load;
            err_next  = job.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (out_adv)
                ovalid_reg <= active;
        end
    end

    // Hold payload of the job and the output beat
    always_ff @(posedge clk)
    begin
        obuf_reg <= obuf_next;
        err_reg  <= err_next;
        if (out_adv && active)
        begin
            obyte_reg <= err_reg ? 8'h00 : obuf_reg[0];
            olast_reg <= (rem_reg == 4'd1);
            oerr_reg  <= err_reg;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;
    assign out_err   = oerr_reg;

endmodule

### hdl/hangul_syllable_decomposer.sv
// ============================================================================
// hangul_syllable_decomposer
// UTF-8 byte stream in, UTF-8 byte stream out, with precomposed Hangul
// syllables split into leading, vowel and optional trailing jamo.
// ============================================================================
// One input byte is taken per cycle while the job queue has room; output
// runs at one byte per cycle while m_axis_tready is high, through the back's
// output register, so the output port sets the pace. Plain text passes one
// byte out for each byte in; a three-byte syllable that splits gives six or
// nine bytes. The first byte of a character passes from the beat that
// completes it through the front register, the queue, the expansion
// register and the output register. A bad lead byte, or end of text in the
// middle of a character, gives one beat with tuser set and tdata zero;
// after a bad lead byte input is dropped up to the beat marked tlast.
// decompose_enable resets to 1; the user must write it only while the block
// is idle, as the block itself does not enforce this.
module hangul_syllable_decomposer (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,       // decompose_enable
    // Input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // end_of_text
    // Output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // last
    output logic       m_axis_tuser    // [0] error
);
    import hsd_pkg::*;

    logic decompose_enable_reg;
    logic fq_valid, fq_ready;
    logic qb_valid, qb_ready;
    job_t fq_job, qb_job;

    // Hold the configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decompose_enable_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            decompose_enable_reg <= cfg_data;
    end

    hsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_eot    (s_axis_tlast),
        .enable    (decompose_enable_reg),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    hsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    hsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_err   (m_axis_tuser)
    );

endmodule

### tb/sv/tb_hangul_syllable_decomposer.sv
// ============================================================================
// tb_hangul_syllable_decomposer
// Self-checking bench for the UTF-8 Hangul syllable decomposer. A table of
// directed bytes is run first, then random texts made mostly of well-formed
// characters, with some noise: bad lead bytes, cut-off characters and raw
// bytes. An in-bench predictor builds the expected output beats, and a
// monitor compares each output beat with the oldest expected one. Both
// stream sides idle at random, and the receiver holds off once for a long
// stretch so that the block fills up and stalls its input.
// ============================================================================
module tb_hangul_syllable_decomposer;

    import hsd_pkg::*;

    localparam int STALL_LIMIT  = 2000;   // cycles with no beat before giving up
    localparam int SETTLE_TICKS = 16;     // drain time after the last result
    localparam int PHASE_ITEMS  = 110;
    localparam int LONG_HOLD    = 400;
    localparam int SPLIT_DIV    = 588;    // vowel count times trail count

    // One output beat: byte, end of this byte's results, error flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } out_beat_t;

    // One directed row; want is used only where typed is set
    typedef struct {
        logic [7:0] data;
        logic       eot;
        bit         typed;
        out_beat_t  want;
    } stim_row_t;

    localparam out_beat_t NO_BEAT  = '0;
    localparam out_beat_t ERR_BEAT = '{8'h00, 1'b1, 1'b1};

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // [7:0] in_byte
    logic       s_axis_tlast;    // end_of_text
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // [7:0] out_byte
    logic       m_axis_tlast;    // last
    logic       m_axis_tuser;    // [0] error

    // Predictor state
    logic [7:0] held_bytes [3];
    logic [2:0] char_len;
    logic [1:0] held_cnt;
    bit         dropping;
    bit         split_en;

    out_beat_t  expected_bytes_q [$];
    out_beat_t  step_bytes_q [$];
    out_beat_t  got_beat;
    out_beat_t  want_beat;

    int  mismatches      = 0;
    int  out_beats       = 0;
    int  idle_cycles     = 0;
    int  burst_left      = 0;
    int  phase_items     = 0;
    bit  long_hold_done  = 1'b0;

    stim_row_t dir_rows [24] = '{
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},   // lowest ASCII
        '{8'h7F, 1'b0, 1'b1, '{8'h7F, 1'b1, 1'b0}},   // highest ASCII
        '{8'h80, 1'b1, 1'b1, ERR_BEAT},               // bad lead on end of text
        '{8'hFF, 1'b0, 1'b1, ERR_BEAT},               // bad lead, start dropping
        '{8'h41, 1'b0, 1'b0, NO_BEAT},                // dropped
        '{8'h42, 1'b1, 1'b0, NO_BEAT},                // end of text clears drop
        '{8'hEA, 1'b0, 1'b0, NO_BEAT},                // first syllable, no trail
        '{8'hB0, 1'b0, 1'b0, NO_BEAT},
        '{8'h80, 1'b0, 1'b0, NO_BEAT},
        '{8'hED, 1'b0, 1'b0, NO_BEAT},                // last syllable, ends text
        '{8'h9E, 1'b0, 1'b0, NO_BEAT},
        '{8'hA3, 1'b1, 1'b0, NO_BEAT},
        '{8'hED, 1'b0, 1'b0, NO_BEAT},                // just past the syllables
        '{8'h9E, 1'b0, 1'b0, NO_BEAT},
        '{8'hA4, 1'b0, 1'b0, NO_BEAT},
        '{8'hC3, 1'b0, 1'b0, NO_BEAT},                // two-byte character
        '{8'hA9, 1'b0, 1'b0, NO_BEAT},
        '{8'hF7, 1'b0, 1'b0, NO_BEAT},                // four bytes, loose tails
        '{8'hBF, 1'b0, 1'b0, NO_BEAT},
        '{8'h3F, 1'b0, 1'b0, NO_BEAT},
        '{8'hC0, 1'b0, 1'b0, NO_BEAT},
        '{8'hE2, 1'b0, 1'b0, NO_BEAT},                // cut off after two bytes
        '{8'h82, 1'b1, 1'b1, ERR_BEAT},
        '{8'hC2, 1'b1, 1'b1, ERR_BEAT}                // cut off on the lead
    };

    hangul_syllable_decomposer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Append one beat to the results of the current input byte
    function automatic void add_step(input out_beat_t beat);
        step_bytes_q = {step_bytes_q, beat};
    endfunction

    // Add one jamo as three UTF-8 bytes
    function automatic void push_jamo(input logic [15:0] cp);
        add_step('{JAMO_HEAD | {4'h0, cp[15:12]}, 1'b0, 1'b0});
        add_step('{CONT_HEAD | {2'b00, cp[11:6]}, 1'b0, 1'b0});
        add_step('{CONT_HEAD | {2'b00, cp[5:0]}, 1'b0, 1'b0});
    endfunction

    // Split a finished character into jamo, or pass its bytes on
    function automatic void emit_char(input logic [7:0] c0, input logic [7:0] c1,
                                      input logic [7:0] c2, input logic [7:0] c3,
                                      input int n);
        logic [20:0] cp;
        int          si;
        case (n)
            1:       cp = {13'd0, c0};
            2:       cp = {10'd0, c0[4:0], c1[5:0]};
            3:       cp = {5'd0, c0[3:0], c1[5:0], c2[5:0]};
            default: cp = {c0[2:0], c1[5:0], c2[5:0], c3[5:0]};
        endcase
        if (split_en && cp >= 21'(SYL_BASE) && cp <= 21'(SYL_LAST))
        begin
            si = int'(cp) - int'(SYL_BASE);
            push_jamo(16'(int'(LEAD_BASE) + si / SPLIT_DIV));
            push_jamo(16'(int'(VOWEL_BASE) + (si % SPLIT_DIV) / int'(TRAIL_COUNT)));
            if (si % int'(TRAIL_COUNT) != 0)
                push_jamo(16'(int'(TRAIL_BASE) + si % int'(TRAIL_COUNT)));
        end
        else
        begin
            add_step('{c0, 1'b0, 1'b0});
            if (n > 1) add_step('{c1, 1'b0, 1'b0});
            if (n > 2) add_step('{c2, 1'b0, 1'b0});
            if (n > 3) add_step('{c3, 1'b0, 1'b0});
        end
        step_bytes_q[step_bytes_q.size() - 1].last = 1'b1;
    endfunction

    // Advance the predictor by one input byte; results go to step_bytes_q
    function automatic void decompose_byte(input logic [7:0] b, input logic eot);
        int         n;
        logic [7:0] chr [4];
        step_bytes_q.delete();
        if (dropping)
        begin
            if (eot)
            begin
                dropping = 1'b0;
                char_len = '0;
                held_cnt = '0;
            end
            return;
        end
        if (held_cnt == 0)
        begin
            if (!b[7])                    n = 1;
            else if (b[7:5] == 3'b110)    n = 2;
            else if (b[7:4] == 4'b1110)   n = 3;
            else if (b[7:3] == 5'b11110)  n = 4;
            else
            begin
                char_len = '0;
                held_cnt = '0;
                dropping = !eot;
                add_step(ERR_BEAT);
                return;
            end
            if (n == 1)
            begin
                emit_char(b, 8'h00, 8'h00, 8'h00, 1);
                return;
            end
            if (eot)
            begin
                add_step(ERR_BEAT);
                return;
            end
            held_bytes[0] = b;
            char_len = 3'(n);
            held_cnt = 2'd1;
            return;
        end
        if (int'(held_cnt) + 1 >= int'(char_len))
        begin
            n = int'(held_cnt) + 1;
            chr[0] = held_bytes[0];
            chr[1] = held_bytes[1];
            chr[2] = held_bytes[2];
            chr[3] = 8'h00;
            chr[n - 1] = b;
            char_len = '0;
            held_cnt = '0;
            emit_char(chr[0], chr[1], chr[2], chr[3], n);
            return;
        end
        if (eot)
        begin
            char_len = '0;
            held_cnt = '0;
            add_step(ERR_BEAT);
            return;
        end
        held_bytes[held_cnt] = b;
        held_cnt = held_cnt + 2'd1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte in bursts with random gaps, then predict on the beat
    task automatic send_byte(input logic [7:0] b, input logic eot, input bit typed,
                             input out_beat_t want);
        int gap;
        bit was_dropping;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                s_axis_tvalid = 1'b0;
            end
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = eot;
        do @(posedge clk); while (!s_axis_tready);
        burst_left--;
        was_dropping = dropping;
        decompose_byte(b, eot);
        if (typed)
            expected_bytes_q = {expected_bytes_q, want};
        else
            foreach (step_bytes_q[i]) expected_bytes_q = {expected_bytes_q, step_bytes_q[i]};
        if (!was_dropping) phase_items++;
    endtask

    // Lower the input valid and wait until every expected beat is out
    task automatic drain_output();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (expected_bytes_q.size() != 0) @(posedge clk);
    endtask

    // Write decompose_enable with the block idle
    task automatic set_enable(input logic value);
        drain_output();
        repeat (SETTLE_TICKS) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        split_en = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Continuation byte; now and then with loose top bits
    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        if ($urandom_range(0, 9) == 0)
            return {2'($urandom_range(0, 3)), bits};
        return {2'b10, bits};
    endfunction

    // Build one random text and send it, end of text on its final byte
    task automatic send_text();
        logic [7:0] txt [$];
        logic [15:0] cp;
        logic [15:0] edges [7] = '{16'hAC00, 16'hAC01, 16'hAC1B, 16'hD7A2,
                                   16'hD7A3, 16'hD7A4, 16'hABFF};
        int  chars;
        int  kind;
        int  n;
        int  k;
        bit  stop;
        chars = $urandom_range(1, 8);
        stop = 1'b0;
        for (int c = 0; c < chars && !stop; c++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                // Hangul syllable, sometimes on a boundary of the block
                if ($urandom_range(0, 6) == 0)
                    cp = edges[$urandom_range(0, 6)];
                else
                    cp = 16'($urandom_range(int'(SYL_BASE), int'(SYL_LAST)));
                txt = {txt, {4'hE, cp[15:12]}};
                txt = {txt, cont_byte(cp[11:6])};
                txt = {txt, cont_byte(cp[5:0])};
            end
            else if (kind < 60)
            begin
                txt = {txt, 8'($urandom_range(0, 127))};
            end
            else if (kind < 70)
            begin
                txt = {txt, {3'b110, 5'($urandom_range(0, 31))}};
                txt = {txt, cont_byte(6'($urandom_range(0, 63)))};
            end
            else if (kind < 80)
            begin
                txt = {txt, {4'hE, 4'($urandom_range(0, 15))}};
                txt = {txt, cont_byte(6'($urandom_range(0, 63)))};
                txt = {txt, cont_byte(6'($urandom_range(0, 63)))};
            end
            else if (kind < 88)
            begin
                txt = {txt, {5'b11110, 3'($urandom_range(0, 7))}};
                repeat (3) txt = {txt, cont_byte(6'($urandom_range(0, 63)))};
            end
            else if (kind < 91)
            begin
                // Bad lead byte
                if ($urandom_range(0, 1) == 0)
                    txt = {txt, {2'b10, 6'($urandom_range(0, 63))}};
                else
                    txt = {txt, {5'b11111, 3'($urandom_range(0, 7))}};
            end
            else if (kind < 96)
            begin
                // Character cut off by the end of text
                n = $urandom_range(2, 4);
                k = $urandom_range(1, n - 1);
                case (n)
                    2:       txt = {txt, {3'b110, 5'($urandom_range(0, 31))}};
                    3:       txt = {txt, {4'hE, 4'($urandom_range(0, 15))}};
                    default: txt = {txt, {5'b11110, 3'($urandom_range(0, 7))}};
                endcase
                repeat (k - 1) txt = {txt, cont_byte(6'($urandom_range(0, 63)))};
                stop = 1'b1;
            end
            else
            begin
                // Raw byte, which may end the text
                txt = {txt, 8'($urandom_range(0, 255))};
                stop = ($urandom_range(0, 3) == 0);
            end
        end
        foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1, 1'b0, NO_BEAT);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall patterns, plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int rx_mode;
        int rx_len;
        int rx_tick;
        m_axis_tready = 1'b0;
        rx_tick = 0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && out_beats >= 150)
            begin
                @(negedge clk);
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_done = 1'b1;
            end
            rx_mode = $urandom_range(0, 3);
            rx_len  = $urandom_range(16, 96);
            repeat (rx_len)
            begin
                @(negedge clk);
                rx_tick++;
                case (rx_mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Output check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            out_beats++;
            got_beat = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
            if (expected_bytes_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: byte %02h last %0d error %0d",
                             got_beat.data, got_beat.last, got_beat.err);
            end
            else
            begin
                want_beat = expected_bytes_q.pop_front();
                if (got_beat !== want_beat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected byte %02h last %0d error %0d, %s",
                                 want_beat.data, want_beat.last, want_beat.err,
                                 $sformatf("got byte %02h last %0d error %0d",
                                           got_beat.data, got_beat.last, got_beat.err));
                end
            end
        end
    end

    // Watchdog: end the run after too long with no beat on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        bit paused;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        held_bytes    = '{8'h00, 8'h00, 8'h00};
        char_len      = '0;
        held_cnt      = '0;
        dropping      = 1'b0;
        split_en      = 1'b1;
        paused        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows, with the enable still at its reset value
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].want);

        // Random phases, alternating the enable between its two values
        for (int p = 0; p < 4; p++)
        begin
            set_enable(p % 2 == 1);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                send_text();
                if (p == 1 && !paused && phase_items >= 50)
                begin
                    drain_output();
                    paused = 1'b1;
                end
            end
        end

        // Wait out the tail
        drain_output();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (expected_bytes_q.size() != 0)
        begin
            mismatches++;
            $display("%0d expected beats never arrived", expected_bytes_q.size());
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
